// ===== src/bip_pkg.sv =====
package bip_pkg;

  localparam int HEADER_BYTES     = 12;
  localparam int MAX_PACKET_BYTES = 4096;
  localparam int BLOCK_BYTES      = 512;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(HEADER_BYTES + 1);

  localparam int CHUNK_CAP = MAX_PACKET_BYTES - HEADER_BYTES;

  localparam logic CFG_MAGIC_FIRST  = 1'b0;
  localparam logic CFG_MAGIC_SECOND = 1'b1;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_HDR  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] len;
    logic [31:0] addr;
    logic [7:0]  data;
    logic        pend;
    logic        iend;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // payload size of the next packet
  function automatic logic [15:0] chunk_size(input logic [31:0] remaining);
    logic [16:0] c;
    logic [16:0] tot;
    logic [16:0] rem_blk;
    if (remaining > 32'(CHUNK_CAP)) begin
      c = 17'(CHUNK_CAP);
    end else begin
      c = remaining[16:0];
    end
    tot     = c + 17'(HEADER_BYTES);
    rem_blk = tot % 17'(BLOCK_BYTES);
    if (tot > 17'(BLOCK_BYTES) && rem_blk != 17'd0) begin
      c = c - rem_blk;
    end
    return c[15:0];
  endfunction

endpackage

// ===== src/bip_front.sv =====
module bip_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [71:0]   in_tdata,
  input  logic          in_tuser,
  input  bip_pkg::q_status_t q_status,
  output logic          push,
  output bip_pkg::cmd_t push_cmd
);
  import bip_pkg::*;

  logic [31:0] bytes_remaining_r, bytes_remaining_nxt;
  logic [15:0] packet_left_r, packet_left_nxt;
  logic [31:0] bytes_sent_r, bytes_sent_nxt;
  logic [31:0] base_address_r, base_address_nxt;
  logic        image_open_r, image_open_nxt;

  logic        accept;
  logic [31:0] load_address;
  logic [31:0] image_length;
  logic [7:0]  payload_byte;
  logic [15:0] pkt_len;
  logic [15:0] pkt_left_dec;
  logic        iend;

  assign in_tready    = !q_status.full;
  assign accept       = in_tvalid && in_tready;
  assign load_address = in_tdata[31:0];
  assign image_length = in_tdata[63:32];
  assign payload_byte = in_tdata[71:64];

  always_comb begin
    bytes_remaining_nxt = bytes_remaining_r;
    packet_left_nxt     = packet_left_r;
    bytes_sent_nxt      = bytes_sent_r;
    base_address_nxt    = base_address_r;
    image_open_nxt      = image_open_r;
    push                = 1'b0;
    push_cmd            = '0;
    pkt_len             = (packet_left_r == 16'd0) ? chunk_size(bytes_remaining_r)
                                                   : packet_left_r;
    pkt_left_dec        = pkt_len - 16'd1;
    iend                = (bytes_remaining_r == 32'd1);
    if (accept) begin
      if (in_tuser == OP_START) begin
        packet_left_nxt     = 16'd0;
        bytes_sent_nxt      = 32'd0;
        base_address_nxt    = load_address;
        bytes_remaining_nxt = image_length;
        if (image_length == 32'd0) begin
          image_open_nxt = 1'b0;
          push           = 1'b1;
          push_cmd.kind  = KIND_DONE;
        end else begin
          image_open_nxt = 1'b1;
        end
      end else if (image_open_r && bytes_remaining_r != 32'd0) begin
        push                = 1'b1;
        push_cmd.kind       = (packet_left_r == 16'd0) ? KIND_HDR : KIND_DATA;
        push_cmd.len        = pkt_len;
        push_cmd.addr       = base_address_r + bytes_sent_r;
        push_cmd.data       = payload_byte;
        push_cmd.iend       = iend;
        push_cmd.pend       = iend || (pkt_left_dec == 16'd0);
        packet_left_nxt     = iend ? 16'd0 : pkt_left_dec;
        bytes_remaining_nxt = bytes_remaining_r - 32'd1;
        bytes_sent_nxt      = bytes_sent_r + 32'd1;
        if (iend) begin
          image_open_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_remaining_r <= '0;
      packet_left_r     <= '0;
      bytes_sent_r      <= '0;
      base_address_r    <= '0;
      image_open_r      <= 1'b0;
    end else begin
      bytes_remaining_r <= bytes_remaining_nxt;
      packet_left_r     <= packet_left_nxt;
      bytes_sent_r      <= bytes_sent_nxt;
      base_address_r    <= base_address_nxt;
      image_open_r      <= image_open_nxt;
    end
  end

endmodule

// ===== src/bip_queue.sv =====
module bip_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bip_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output bip_pkg::cmd_t      head,
  output bip_pkg::q_status_t q_status
);
  import bip_pkg::*;

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign q_status.empty = (count_r == QCNT_W'(0));
  assign q_status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/bip_back.sv =====
module bip_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  bip_pkg::cmd_t      head,
  input  bip_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);
  import bip_pkg::*;

  logic [7:0]       magic_first_r;
  logic [7:0]       magic_second_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_pend_r;
  logic             out_iend_r;

  logic             load;
  logic [7:0]       hdr_byte;
  logic [7:0]       sel_byte;
  logic             sel_last;
  logic             sel_pend;
  logic             sel_iend;

  assign load       = !out_valid_r || out_tready;
  assign pop        = load && !q_status.empty && sel_last;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_pend_r;
  assign out_tuser  = out_iend_r;

  always_comb begin
    hdr_byte = 8'd0;
    if (idx_r == IDX_W'(0)) begin
      hdr_byte = magic_first_r;
    end else if (idx_r == IDX_W'(1)) begin
      hdr_byte = magic_second_r;
    end else if (idx_r == IDX_W'(2)) begin
      hdr_byte = head.len[7:0];
    end else if (idx_r == IDX_W'(3)) begin
      hdr_byte = head.len[15:8];
    end else if (idx_r == IDX_W'(4)) begin
      hdr_byte = head.addr[7:0];
    end else if (idx_r == IDX_W'(5)) begin
      hdr_byte = head.addr[15:8];
    end else if (idx_r == IDX_W'(6)) begin
      hdr_byte = head.addr[23:16];
    end else if (idx_r == IDX_W'(7)) begin
      hdr_byte = head.addr[31:24];
    end
  end

  always_comb begin
    sel_byte = hdr_byte;
    sel_last = 1'b0;
    sel_pend = 1'b0;
    sel_iend = 1'b0;
    unique case (head.kind)
      KIND_DATA: begin
        sel_byte = head.data;
        sel_last = 1'b1;
        sel_pend = head.pend;
        sel_iend = head.iend;
      end
      KIND_HDR: begin
        if (idx_r == IDX_W'(HEADER_BYTES)) begin
          sel_byte = head.data;
          sel_last = 1'b1;
          sel_pend = head.pend;
          sel_iend = head.iend;
        end
      end
      KIND_DONE: begin
        sel_last = (idx_r == IDX_W'(HEADER_BYTES - 1));
        sel_pend = sel_last;
        sel_iend = sel_last;
      end
      default: begin
        sel_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= 8'd83;
      magic_second_r <= 8'd68;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAGIC_FIRST:  magic_first_r  <= cfg_wdata;
        CFG_MAGIC_SECOND: magic_second_r <= cfg_wdata;
        default:          magic_first_r  <= magic_first_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= !q_status.empty;
      if (!q_status.empty) begin
        idx_r <= sel_last ? '0 : idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= sel_byte;
      out_pend_r <= sel_pend;
      out_iend_r <= sel_iend;
    end
  end

endmodule

// ===== src/boot_image_packetizer_top.sv =====
// boot image packetizer
// input stream: one transaction per item; in_tuser is the op (0 start, 1 payload
// byte). a start carries load address and image length, a payload transaction
// carries one image byte. payload bytes with no open image are dropped.
// output stream: one framed byte per transaction; out_tlast marks the last byte
// of a packet, out_tuser the last byte of the image.
// config: cfg_we with cfg_index 0 writes magic_first, 1 writes magic_second;
// write only while the block is idle.
// path: the first byte caused by an input transaction is written into the queue
// when the transaction is accepted and then loaded into the output register.
// throughput: one output byte per cycle while commands wait and out_tready is high,
// set by the output register. a payload byte opening a packet yields 13 output
// bytes (12 header bytes plus the byte), other payload bytes one byte, a zero-length
// start 12 header bytes. a 4-entry command queue between the front and back parts
// absorbs header bursts; in_tready drops while it is full.
// reset: image closed, counters cleared, magic bytes back to 83 and 68, queue
// and output emptied. a stalled receiver holds the output byte and fills the
// queue, which then stalls the input.
module boot_image_packetizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // load_address[31:0], image_length[63:32], payload_byte[71:64]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast,
  output logic        out_tuser,  // image_end
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import bip_pkg::*;

  q_status_t q_status;
  cmd_t      push_cmd;
  cmd_t      head;
  logic      push;
  logic      pop;

  bip_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  bip_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  bip_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== src/bip_checker.sv =====
module bip_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // image end always closes a packet
  a_iend_pend: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("image end without packet end");

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output changed while stalled");

  // reset empties the output
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // queue is empty after reset so input is ready
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready right after reset");

endmodule

bind boot_image_packetizer_top bip_checker u_bip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bip_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       pend;
    logic       iend;
  } frame_byte_t;

  localparam int STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  // packetizer state as seen by the testbench
  logic [7:0]  magic_lead;
  logic [7:0]  magic_trail;
  logic [31:0] image_bytes_due;
  logic [15:0] pkt_payload_left;
  logic [31:0] image_bytes_done;
  logic [31:0] image_base;
  logic        image_active;

  frame_byte_t expected_bytes[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  int unsigned ready_hold = 0;
  logic        calm = 1'b0;

  boot_image_packetizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] packet_payload_size(input logic [31:0] due);
    longint unsigned c;
    longint unsigned total;
    c = 64'(due);
    if (c > MAX_PACKET_BYTES - HEADER_BYTES) begin
      c = 64'(MAX_PACKET_BYTES - HEADER_BYTES);
    end
    total = c + HEADER_BYTES;
    if (total > BLOCK_BYTES && (total % BLOCK_BYTES) != 0) begin
      c = c - (total % BLOCK_BYTES);
    end
    return c[15:0];
  endfunction

  task automatic push_header(input logic [15:0] len, input logic [31:0] addr,
                             input logic done);
    logic [7:0] b;
    logic       last;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      b = 8'h00;
      if (i == 0) begin
        b = magic_lead;
      end else if (i == 1) begin
        b = magic_trail;
      end else if (!done && i == 2) begin
        b = len[7:0];
      end else if (!done && i == 3) begin
        b = len[15:8];
      end else if (!done && i >= 4 && i < 8) begin
        b = addr[8*(i-4) +: 8];
      end
      last = done && (i == HEADER_BYTES - 1);
      expected_bytes.push_back('{data: b, pend: last, iend: last});
    end
  endtask

  task automatic frame_item(input logic op, input logic [31:0] addr, input logic [31:0] len,
                            input logic [7:0] pb);
    logic image_done;
    if (op == OP_START) begin
      pkt_payload_left = '0;
      image_bytes_done = '0;
      image_base = addr;
      image_bytes_due = len;
      if (len == 0) begin
        image_active = 1'b0;
        push_header(16'd0, 32'd0, 1'b1);
      end else begin
        image_active = 1'b1;
      end
    end else if (image_active && image_bytes_due != 0) begin
      if (pkt_payload_left == 0) begin
        pkt_payload_left = packet_payload_size(image_bytes_due);
        push_header(pkt_payload_left, image_base + image_bytes_done, 1'b0);
      end
      pkt_payload_left = pkt_payload_left - 16'd1;
      image_bytes_due = image_bytes_due - 32'd1;
      image_bytes_done = image_bytes_done + 32'd1;
      image_done = (image_bytes_due == 0);
      expected_bytes.push_back('{data: pb, pend: (pkt_payload_left == 0) || image_done,
                                 iend: image_done});
      if (image_done) begin
        image_active = 1'b0;
        pkt_payload_left = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
  endtask

  task automatic send_item(input logic op, input logic [31:0] addr, input logic [31:0] len,
                           input logic [7:0] pb);
    logic ignored;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {pb, len, addr};
    do @(posedge clk); while (!in_tready);
    ignored = (op == OP_PAYLOAD) && !(image_active && image_bytes_due != 0);
    if (!ignored) begin
      items_sent++;
    end
    frame_item(op, addr, len, pb);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic send_start(input logic [31:0] addr, input logic [31:0] len);
    send_item(OP_START, addr, len, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] pb);
    send_item(OP_PAYLOAD, $urandom, $urandom, pb);
  endtask

  task automatic wait_drained;
    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_magic(input logic idx, input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_MAGIC_FIRST) begin
      magic_lead = value;
    end else begin
      magic_trail = value;
    end
  endtask

  task automatic test_done_after_reset;
    send_start(32'hFFFF_FFFF, 32'd0);
    send_byte(8'hA5);
  endtask

  task automatic test_edge_images;
    send_start(32'hFFFF_FFFF, 32'd1);
    send_byte(8'hFF);
    send_start(32'h0000_0000, 32'd2);
    send_byte(8'h00);
    send_byte(8'h80);
    // byte after the image closed
    send_byte(8'h5A);
    // abandoned image, then one with the largest length
    send_start(32'h8000_0000, 32'd10);
    send_byte(8'h01);
    send_byte(8'h02);
    send_start(32'h1234_5678, 32'hFFFF_FFFF);
    send_byte(8'h7F);
    // zero length closes the open image
    send_start(32'hDEAD_BEEF, 32'd0);
    send_byte(8'h3C);
  endtask

  task automatic test_magic_extremes;
    wait_drained();
    write_magic(CFG_MAGIC_FIRST, 8'h00);
    write_magic(CFG_MAGIC_SECOND, 8'hFF);
    send_start(32'h0000_0010, 32'd0);
    send_start(32'h0000_0020, 32'd2);
    send_byte(8'hC3);
    send_byte(8'h3C);
  endtask

  task automatic test_packet_split;
    logic [31:0] len;
    len = $urandom_range(501, 540);
    // first packet is trimmed to a whole block
    send_start(32'hFFFF_FF00 | 32'($urandom_range(0, 255)), len);
    repeat ($urandom_range(2, 6)) send_byte(8'($urandom));
  endtask

  task automatic test_random_images(input int unsigned item_goal);
    int unsigned first_count;
    int unsigned pick;
    int unsigned len;
    int unsigned n;
    first_count = items_sent;
    while (items_sent - first_count < item_goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        len = $urandom_range(1, 24);
        send_start($urandom, len);
        repeat (len) send_byte(8'($urandom));
      end else if (pick == 6) begin
        len = $urandom_range(2, 40);
        n = $urandom_range(1, len - 1);
        send_start($urandom, len);
        repeat (n) send_byte(8'($urandom));
      end else if (pick == 7) begin
        send_start($urandom, 32'd0);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else begin
        len = $urandom;
        if (len < 64) begin
          len = len + 64;
        end
        send_start($urandom, len);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      ready_hold <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_output
    frame_byte_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", 32'(out_tdata), 32'd0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata !== want.data) begin
          report_mismatch("out_tdata", 32'(out_tdata), 32'(want.data));
        end
        if (out_tlast !== want.pend) begin
          report_mismatch("out_tlast", 32'(out_tlast), 32'(want.pend));
        end
        if (out_tuser !== want.iend) begin
          report_mismatch("out_tuser", 32'(out_tuser), 32'(want.iend));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    magic_lead = 8'd83;
    magic_trail = 8'd68;
    image_bytes_due = '0;
    pkt_payload_left = '0;
    image_bytes_done = '0;
    image_base = '0;
    image_active = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_done_after_reset();
    test_edge_images();
    test_magic_extremes();
    test_random_images(80);
    wait_drained();
    write_magic(CFG_MAGIC_FIRST, 8'($urandom));
    write_magic(CFG_MAGIC_SECOND, 8'($urandom));
    test_packet_split();
    test_random_images(70);
    wait_drained();
    write_magic(CFG_MAGIC_FIRST, 8'hFF);
    write_magic(CFG_MAGIC_SECOND, 8'h00);
    calm = 1'b1;
    test_random_images(40);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bip_pkg.sv
src/bip_front.sv
src/bip_queue.sv
src/bip_back.sv
src/boot_image_packetizer_top.sv
src/bip_checker.sv
bench/tb_top.sv
